/* src/packet_header_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// Packet header parser assertion macros
// Shared concurrent assertion forms for the header parser checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_PARSER_CORE_MACROS_SVH
`define PACKET_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("header parser assertion failed");

// next-cycle implication, disabled during reset
`define PHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("header parser assertion failed");

`endif

/* src/php_pkg.sv */
// ----------------------------------------------------------------------------
// Packet header parser package
// Result type, status codes and field widths shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package php_pkg;

  localparam int unsigned TagW    = 6;
  localparam int unsigned LenW    = 32;
  localparam int unsigned HdrCntW = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusReqBit  = 2'd1;
  localparam logic [StatusW-1:0] StatusPartial = 2'd2;

  // packed with tag in the low bits, matching the output tdata layout
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HdrCntW-1:0] header_bytes;
    logic               new_format;
    logic               length_known;
    logic [LenW-1:0]    body_length;
    logic [TagW-1:0]    tag;
  } php_result_t;

  localparam int unsigned ResultW = $bits(php_result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

`default_nettype wire

/* src/php_decoder.sv */
// ----------------------------------------------------------------------------
// Packet header decoder
// Holds the header parse state and decodes one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module php_decoder
  import php_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        begin_req_i,
  output logic             emit_o,
  output php_result_t      result_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NEWLEN,
    PH_SHIFT,
    PH_ADD
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [2:0]         left_q, left_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic               fmt_q, fmt_d;
  logic [HdrCntW-1:0] cnt_q, cnt_d;

  logic [HdrCntW-1:0] cnt_inc;
  logic [LenW-1:0]    acc_sum;
  logic [LenW-1:0]    acc_shift;
  logic [2:0]         left_dec;
  logic [TagW-1:0]    old_tag;

  assign cnt_inc   = cnt_q + 3'd1;
  assign acc_sum   = acc_q + {24'd0, data_byte_i};
  assign acc_shift = {acc_q[23:0], data_byte_i};
  assign left_dec  = (left_q == 3'd0) ? 3'd0 : left_q - 3'd1;
  assign old_tag   = {2'b00, data_byte_i[5:2]};

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    acc_d    = acc_q;
    tag_d    = tag_q;
    fmt_d    = fmt_q;
    cnt_d    = cnt_q;
    emit_o   = 1'b0;
    result_o = '0;
    if (step_i) begin
      if (begin_req_i) begin
        cnt_d = 3'd1;
        acc_d = '0;
        if (!data_byte_i[7]) begin
          emit_o                = 1'b1;
          result_o.header_bytes = 3'd1;
          result_o.status       = StatusReqBit;
        end else if (data_byte_i[6]) begin
          fmt_d   = 1'b1;
          tag_d   = data_byte_i[5:0];
          phase_d = PH_NEWLEN;
          left_d  = 3'd1;
        end else begin
          fmt_d   = 1'b0;
          tag_d   = old_tag;
          phase_d = PH_SHIFT;
          unique case (data_byte_i[1:0])
            2'd0: left_d = 3'd1;
            2'd1: left_d = 3'd2;
            2'd2: left_d = 3'd4;
            default: begin
              // indeterminate length: header is the single byte
              emit_o                = 1'b1;
              result_o.tag          = old_tag;
              result_o.header_bytes = 3'd1;
              result_o.status       = StatusOk;
            end
          endcase
        end
      end else if (phase_q != PH_IDLE) begin
        cnt_d                 = cnt_inc;
        result_o.tag          = tag_q;
        result_o.header_bytes = cnt_inc;
        unique case (phase_q)
          PH_NEWLEN: begin
            priority if (data_byte_i < 8'd192) begin
              emit_o                = 1'b1;
              result_o.body_length  = {24'd0, data_byte_i};
              result_o.length_known = 1'b1;
              result_o.new_format   = 1'b1;
              result_o.status       = StatusOk;
            end else if (data_byte_i < 8'd224) begin
              // two-octet form: ((b1 - 192) << 8) + 192, b2 added next
              acc_d   = {19'd0, data_byte_i[4:0], 8'hC0};
              left_d  = 3'd1;
              phase_d = PH_ADD;
            end else if (data_byte_i == 8'hFF) begin
              acc_d   = '0;
              left_d  = 3'd4;
              phase_d = PH_SHIFT;
            end else begin
              emit_o              = 1'b1;
              result_o.new_format = 1'b1;
              result_o.status     = StatusPartial;
            end
          end
          PH_ADD: begin
            acc_d                 = acc_sum;
            emit_o                = 1'b1;
            result_o.body_length  = acc_sum;
            result_o.length_known = 1'b1;
            result_o.new_format   = fmt_q;
            result_o.status       = StatusOk;
          end
          default: begin
            acc_d  = acc_shift;
            left_d = left_dec;
            if (left_dec == 3'd0) begin
              emit_o                = 1'b1;
              result_o.body_length  = acc_shift;
              result_o.length_known = 1'b1;
              result_o.new_format   = fmt_q;
              result_o.status       = StatusOk;
            end
          end
        endcase
      end
      if (emit_o) begin
        phase_d = PH_IDLE;
        left_d  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 3'd0;
      acc_q   <= '0;
      tag_q   <= '0;
      fmt_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      tag_q   <= tag_d;
      fmt_q   <= fmt_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* src/packet_header_parser_core.sv */
// ----------------------------------------------------------------------------
// Packet header parser core
//
// Input stream s_axis: one header byte per transfer in tdata, tuser set on
// the first byte of a header (restarts the parser, abandoning any header in
// progress). Bytes without tuser while no header is open are dropped.
// Output stream m_axis: one transfer per completed header with tag, body
// length, flags, header byte count and status; malformed headers (bit 7
// clear, partial-length octet) also give one transfer with an error status.
// Throughput is one byte per cycle while m_axis does not stall. The byte
// that completes the header is registered in the input register, then
// decoded into the result register, from which the result leaves. When
// m_axis stalls, the result holds and the input register keeps its byte;
// s_axis tready drops only while both stages are full and the output is
// not taken. Reset clears both stages and returns the parser to the idle
// state, waiting for a header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_parser_core
  import php_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // data_byte
  input  wire logic                s_axis_tuser_i,   // begin_req
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tag[5:0], body_length[37:6], length_known[38], new_format[39],
  // header_bytes[42:40], status[44:43], zero pad[47:45]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_begin_q;
  logic        advance;
  logic        emit;
  php_result_t result;
  logic        out_valid_q, out_valid_d;
  php_result_t out_data_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_begin_q <= s_axis_tuser_i;
    end
  end

  php_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .begin_req_i (in_begin_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResultW){1'b0}}, out_data_q};

endmodule

`default_nettype wire

/* src/php_checker.sv */
// ----------------------------------------------------------------------------
// Packet header parser checker
// Port-level assertions on result consistency and output stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_header_parser_core_macros.svh"

module php_checker
  import php_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [7:0]          s_axis_tdata_i,
  input wire logic                s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  php_result_t res;
  logic        out_stall;

  assign res       = m_axis_tdata_o[ResultW-1:0];
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a stalled result transfer keeps its payload
  `PHP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // missing bit 7 reports a bare one-byte header
  `PHP_ASSERT_IMP(a_reqbit_shape, clk_i, rst_ni,
    m_axis_tvalid_o && res.status == StatusReqBit,
    res.tag == '0 && res.body_length == '0 && !res.length_known &&
    !res.new_format && res.header_bytes == 3'd1)

  // partial length only arises on the first new-format length octet
  `PHP_ASSERT_IMP(a_partial_shape, clk_i, rst_ni,
    m_axis_tvalid_o && res.status == StatusPartial,
    res.new_format && !res.length_known && res.body_length == '0 &&
    res.header_bytes == 3'd2)

  // an ok result without length is the old-format indeterminate header
  `PHP_ASSERT_IMP(a_indet_shape, clk_i, rst_ni,
    m_axis_tvalid_o && res.status == StatusOk && !res.length_known,
    !res.new_format && res.header_bytes == 3'd1 && res.body_length == '0 &&
    res.tag[5:4] == 2'b00)

  // the input-side ports, handshake included, are unused
  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ s_axis_tready_o ^ (^s_axis_tdata_i) ^ s_axis_tuser_i;

endmodule

bind packet_header_parser_core php_checker u_php_checker (.*);

`default_nettype wire
